// ===== rtl/qvla_pkg.sv =====
// Package for the quorum vote lock arbiter: word types, message codes, sizes, register indices.
// No dependencies; imported by every module of the block.
package qvla_pkg;

	localparam int QueueDepthDef = 16;
	localparam int MaxProcessesDef = 16;

	localparam logic [2:0] K_REQUEST = 3'd0;
	localparam logic [2:0] K_VOTE = 3'd1;
	localparam logic [2:0] K_RELEASE = 3'd2;
	localparam logic [2:0] K_INQUIRE = 3'd3;
	localparam logic [2:0] K_RELINQ = 3'd4;
	localparam logic [2:0] K_LREQ = 3'd5;
	localparam logic [2:0] K_LREL = 3'd6;
	localparam logic [2:0] K_ENTER = 3'd5;

	localparam logic [1:0] REG_PCOUNT = 2'd0;
	localparam logic [1:0] REG_SITE = 2'd1;
	localparam logic [1:0] REG_PROC = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] msg_clock;
		logic [3:0]  sender_site;
		logic [3:0]  sender_proc;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  out_kind;
		logic        broadcast;
		logic [3:0]  dest_site;
		logic [3:0]  dest_proc;
		logic [31:0] out_clock;
		logic        queue_dropped;
	} out_word_t;

	typedef struct packed {
		logic [31:0] clk;
		logic [3:0]  site;
		logic [3:0]  proc;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input word, begin item
		logic ins;      // do insert step (shift one entry)
		logic pop;      // do pop step (shift one entry)
		logic fin;      // finish item, produce result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic want_ins;
		logic ins_done;
		logic want_pop;
		logic pop_done;
	} stat_t;

endpackage

// ===== rtl/qvla_ctrl.sv =====
// Controller state machine for the arbiter: sequences load, queue shift steps, finish.
// Depends on qvla_pkg.
module qvla_ctrl import qvla_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_busy,
	input  stat_t st,
	output logic  in_stall,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_INS = 3'd2;
	localparam logic [2:0] S_POP = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// decode next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (st.want_ins) state_d = S_INS;
				else if (st.want_pop) state_d = S_POP;
				else state_d = S_FIN;
			end
			S_INS: begin
				cmd.ins = 1'b1;
				if (st.ins_done) state_d = st.want_pop ? S_POP : S_FIN;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				if (st.pop_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_busy) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

// ===== rtl/qvla_dp.sv =====
// Datapath of the arbiter: protocol state, sorted wait queue, result register.
// Depends on qvla_pkg; stepped by qvla_ctrl.
module qvla_dp import qvla_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int MAX_PROCESSES = MaxProcessesDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_word,
	input  cmd_t      cmd,
	output stat_t     st,
	input  logic [4:0] cfg_pcount,
	input  logic [3:0] cfg_site,
	input  logic [3:0] cfg_proc,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word,
	output logic      out_busy
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [LW-1:0] QFULL = LW'(QUEUE_DEPTH);
	localparam logic [4:0] NEEDMAX = (MAX_PROCESSES > 31) ? 5'd31 : 5'(MAX_PROCESSES);

	entry_t q_q [QUEUE_DEPTH];
	logic [LW-1:0] qlen_q;
	logic [LW-1:0] pos_q;          // shift cursor
	logic [31:0] lclk_q;
	logic vote_q, inq_q, drop_q;
	entry_t hold_q;
	logic [4:0] votes_q;
	in_word_t w_q;
	logic ins_q, pop_q;            // pending steps for current item
	entry_t ins_e_q;
	logic [2:0] act_q;             // what to send after queue work
	localparam logic [2:0] A_NONE = 3'd0, A_INQ = 3'd1, A_VHEAD = 3'd2, A_RELQ = 3'd3;

	logic [4:0] need;
	logic [31:0] mclk;
	logic [IW-1:0] pidx, pidx_m1, pidx_p1;
	logic ins_here;
	entry_t head;

	assign need = (cfg_pcount > NEEDMAX) ? NEEDMAX : cfg_pcount;
	assign mclk = ((lclk_q > in_word.msg_clock) ? lclk_q : in_word.msg_clock) + 32'd1;
	assign pidx = pos_q[IW-1:0];
	assign pidx_m1 = pidx - IW'(1);
	assign pidx_p1 = pidx + IW'(1);
	assign head = q_q[0];
	assign out_busy = out_valid && out_stall;

	// insert walks from the tail down: entry pos-1 moves up while the new one sorts
	// at or before it, so a new word lands ahead of any entry with equal clock and id
	assign ins_here = (pos_q == '0) ||
		!((ins_e_q.clk < q_q[pidx_m1].clk) ||
		  (ins_e_q.clk == q_q[pidx_m1].clk && ins_e_q.proc <= q_q[pidx_m1].proc));

	assign st.want_ins = ins_q;
	assign st.ins_done = ins_here;
	assign st.want_pop = pop_q;
	assign st.pop_done = (pos_q + LW'(1) >= qlen_q);

	// queue shifting
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (ins_here) q_q[pidx] <= ins_e_q;
			else q_q[pidx] <= q_q[pidx_m1];
		end else if (cmd.pop && (pos_q + LW'(1) < qlen_q)) begin
			q_q[pidx] <= q_q[pidx_p1];
		end
	end

	// protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q <= '0; pos_q <= '0; lclk_q <= '0; vote_q <= 1'b0; inq_q <= 1'b0;
			drop_q <= 1'b0; hold_q <= '0; votes_q <= '0; ins_q <= 1'b0; pop_q <= 1'b0;
			act_q <= A_NONE; out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.load) begin
				w_q <= in_word;
				ins_q <= 1'b0; pop_q <= 1'b0; act_q <= A_NONE;
				pos_q <= '0;
				if (in_word.kind <= K_RELINQ) lclk_q <= mclk;
				case (in_word.kind)
					K_REQUEST: begin
						if (vote_q) begin
							ins_e_q <= '{clk: in_word.msg_clock, site: in_word.sender_site,
								proc: in_word.sender_proc};
							if (qlen_q >= QFULL) drop_q <= 1'b1;
							else begin ins_q <= 1'b1; pos_q <= qlen_q; end
							if (((in_word.msg_clock < hold_q.clk) ||
								(in_word.msg_clock == hold_q.clk &&
								 in_word.sender_proc < hold_q.proc)) && !inq_q) begin
								act_q <= A_INQ; inq_q <= 1'b1;
							end
						end
					end
					K_RELEASE: begin
						inq_q <= 1'b0;
						if (qlen_q != '0) begin pop_q <= 1'b1; act_q <= A_VHEAD; end
						else vote_q <= 1'b0;
					end
					K_RELINQ: begin
						inq_q <= 1'b0;
						ins_e_q <= hold_q;
						if (qlen_q >= QFULL) drop_q <= 1'b1;
						else begin ins_q <= 1'b1; pos_q <= qlen_q; end
						if (qlen_q != '0 || qlen_q < QFULL) begin
							pop_q <= 1'b1; act_q <= A_RELQ;
						end
					end
					default: ;
				endcase
			end
			if (cmd.ins) begin
				if (ins_here) begin
					qlen_q <= qlen_q + LW'(1);
					ins_q <= 1'b0;
				end else pos_q <= pos_q - LW'(1);
			end
			if (cmd.pop) begin
				if (pos_q == '0) begin
					// decide at head: a requeued holder at the head is just dropped
					if (act_q == A_RELQ && head.site == hold_q.site &&
						head.proc == hold_q.proc) begin
						act_q <= A_NONE;
					end else if (act_q == A_RELQ || act_q == A_VHEAD) begin
						act_q <= A_VHEAD;
						hold_q <= head; vote_q <= 1'b1;
					end
				end
				if (pos_q + LW'(1) >= qlen_q) begin
					qlen_q <= qlen_q - LW'(1);
					pop_q <= 1'b0;
					pos_q <= '0;
				end else pos_q <= pos_q + LW'(1);
			end
			if (cmd.ins && ins_here) pos_q <= '0;
			if (cmd.fin) begin
				out_word.queue_dropped <= drop_q;
				out_word.broadcast <= 1'b0;
				out_word.out_clock <= lclk_q + 32'd1;
				case (w_q.kind)
					K_REQUEST: begin
						if (!vote_q) begin
							hold_q <= '{clk: w_q.msg_clock, site: w_q.sender_site,
								proc: w_q.sender_proc};
							vote_q <= 1'b1;
							lclk_q <= lclk_q + 32'd1; out_valid <= 1'b1; drop_q <= 1'b0;
							out_word.out_kind <= K_VOTE;
							out_word.dest_site <= w_q.sender_site;
							out_word.dest_proc <= w_q.sender_proc;
						end else if (act_q == A_INQ) begin
							lclk_q <= lclk_q + 32'd1; out_valid <= 1'b1; drop_q <= 1'b0;
							out_word.out_kind <= K_INQUIRE;
							out_word.dest_site <= hold_q.site;
							out_word.dest_proc <= hold_q.proc;
						end
					end
					K_VOTE: begin
						if (need != 5'd0 &&
							((votes_q < 5'd31) ? votes_q + 5'd1 : votes_q) == need) begin
							votes_q <= '0; out_valid <= 1'b1; drop_q <= 1'b0;
							out_word.out_kind <= K_ENTER;
							out_word.dest_site <= cfg_site;
							out_word.dest_proc <= cfg_proc;
							out_word.out_clock <= lclk_q;
						end else if (votes_q < 5'd31) votes_q <= votes_q + 5'd1;
					end
					K_INQUIRE: begin
						if (votes_q != need && votes_q != 5'd0) begin
							votes_q <= votes_q - 5'd1;
							lclk_q <= lclk_q + 32'd1; out_valid <= 1'b1; drop_q <= 1'b0;
							out_word.out_kind <= K_RELINQ;
							out_word.dest_site <= w_q.sender_site;
							out_word.dest_proc <= w_q.sender_proc;
						end
					end
					K_RELEASE, K_RELINQ: begin
						if (act_q == A_VHEAD) begin
							lclk_q <= lclk_q + 32'd1; out_valid <= 1'b1; drop_q <= 1'b0;
							out_word.out_kind <= K_VOTE;
							out_word.dest_site <= hold_q.site;
							out_word.dest_proc <= hold_q.proc;
						end
					end
					K_LREQ, K_LREL: begin
						lclk_q <= lclk_q + 32'd1; out_valid <= 1'b1; drop_q <= 1'b0;
						out_word.out_kind <= (w_q.kind == K_LREQ) ? K_REQUEST : K_RELEASE;
						out_word.broadcast <= 1'b1;
						out_word.dest_site <= cfg_site;
						out_word.dest_proc <= 4'd0;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== rtl/qvla_regs.sv =====
// Configuration registers of the arbiter behind an APB-style port.
// Depends on qvla_pkg.
module qvla_regs import qvla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [4:0]  pcount,
	output logic [3:0]  site,
	output logic [3:0]  proc
);

	logic [1:0] idx;
	logic [4:0] pcount_q;
	logic [3:0] site_q, proc_q;

	assign idx = paddr[3:2];
	assign pready = 1'b1;
	assign pcount = pcount_q;
	assign site = site_q;
	assign proc = proc_q;

	// write on access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= 5'd1; site_q <= '0; proc_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_PCOUNT: pcount_q <= pwdata[4:0];
				REG_SITE: site_q <= pwdata[3:0];
				REG_PROC: proc_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_PCOUNT: prdata = {27'd0, pcount_q};
			REG_SITE: prdata = {28'd0, site_q};
			REG_PROC: prdata = {28'd0, proc_q};
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/quorum_vote_lock_arbiter_unit.sv =====
// Quorum vote lock arbiter: one node of a voting mutual-exclusion protocol.
// A word is loaded and decoded, then any queue work runs in steps: an insert
// moves one entry up per step until the new entry's slot, a head removal takes
// one step per queued entry (release, relinquish). The result is registered at
// finish; the next word is accepted only after that, and a stalled result delays
// only the finish of the next word. Reset (arst_n low) clears clock, vote,
// counters, queue length, and resets the configuration registers.
module quorum_vote_lock_arbiter_unit import qvla_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int MAX_PROCESSES = MaxProcessesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t cmd;
	stat_t st;
	logic busy;
	logic [4:0] pcount;
	logic [3:0] site, proc;

	qvla_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .pcount, .site, .proc);

	qvla_ctrl u_ctrl (.clk, .arst_n, .in_valid, .out_busy(busy), .st, .in_stall, .cmd);

	qvla_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_PROCESSES(MAX_PROCESSES)) u_dp (
		.clk, .arst_n, .in_word(in_data), .cmd, .st, .cfg_pcount(pcount),
		.cfg_site(site), .cfg_proc(proc), .out_valid, .out_stall,
		.out_word(out_data), .out_busy(busy));

endmodule

// ===== rtl/qvla_checker.sv =====
// Port-level checks for the arbiter, bound to the top level.
// Depends on qvla_pkg.
module qvla_checker import qvla_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data
);

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed under stall");

	// drop stall after accept only later; accept makes block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken back to back");

	// never report unknown output kind
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.out_kind <= K_ENTER)
		else $error("bad out_kind");

endmodule

bind quorum_vote_lock_arbiter_unit qvla_checker u_chk (.clk, .arst_n, .in_valid,
	.in_stall, .out_valid, .out_stall, .out_data);
